// ===== src/spg_pkg.sv =====
package spg_pkg;

  localparam int AXES_DEF = 7;

  // result fields carry one bit for each of the first seven axes
  localparam int OUT_W = 7;

  localparam int RATE_W = 20;
  localparam int DIV_STEPS = RATE_W;
  localparam logic [RATE_W-1:0] US_PER_SEC = 20'd1000000;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // per-axis record held in the state memory
  typedef struct packed {
    logic [31:0]       last_us;
    logic [23:0]       steps;
    logic [RATE_W-1:0] interval;
    logic              cdir;
    logic              rate_zero;
  } axis_entry_t;

endpackage

// ===== src/multi_axis_step_pulse_generator.sv =====
// Channel  Beat fields                                          Handshake
// in       op axis time_us step_count step_rate_hz direction    in_valid / in_stall
// out      step_mask dir_levels running_mask                    out_valid / out_stall
//
// Tick: the axis records are walked one memory read per cycle.
// Start: runs the 20-step interval divider, skipped with a zero rate or an out-of-range axis;
// stop and all other beats go straight to the finish state.
// One item at a time; in_stall is high from acceptance until the result is loaded.
// The result register holds while out_stall is high; the block then waits to load.
// Reset clears running flags, direction pins and handshake state; memory needs no clear.
module multi_axis_step_pulse_generator #(
  parameter int AXES = spg_pkg::AXES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [2:0]  axis,
  input  logic [31:0] time_us,
  input  logic [23:0] step_count,
  input  logic [19:0] step_rate_hz,
  input  logic        direction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  step_mask,
  output logic [6:0]  dir_levels,
  output logic [6:0]  running_mask
);

  localparam int AW = AXES > 1 ? $clog2(AXES) : 1;
  localparam int CW = $clog2(AXES + 1);
  localparam int IW = AW > 3 ? AW : 3;
  localparam int EW = $bits(spg_pkg::axis_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_DIV,
    ST_WR,
    ST_FIN
  } state_t;

  state_t state;

  logic [AXES-1:0] running;
  logic [AXES-1:0] dir_pin;
  logic [AXES-1:0] smask;

  logic [CW-1:0] cnt;
  logic          p_vld;
  logic [AW-1:0] p_idx;

  spg_pkg::op_t  op_q;
  logic [AW-1:0] idx_q;
  logic [31:0]   time_q;
  logic [23:0]   count_q;
  logic          dir_q;
  logic          rz_q;

  logic          in_acc;
  logic [IW-1:0] axis_ext;
  logic [AW-1:0] axis_idx;
  logic          in_range;

  logic                       div_start;
  logic                       div_done;
  logic [spg_pkg::RATE_W-1:0] div_q;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  spg_pkg::axis_entry_t ram_wdata;
  spg_pkg::axis_entry_t ent;
  logic [EW-1:0]        ram_rdata;

  logic [31:0] elapsed;
  logic        hit;
  logic        stop_now;
  logic [23:0] steps_n;
  logic        out_load;

  logic [6:0] smask7;
  logic [6:0] dir7;
  logic [6:0] run7;

  assign in_stall = state != ST_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign axis_ext = IW'(axis);
  assign axis_idx = axis_ext[AW-1:0];
  assign in_range = {2'b00, axis} < 5'(AXES);
  assign out_load = state == ST_FIN && (!out_valid || !out_stall);

  assign div_start = in_acc && spg_pkg::op_t'(op) == spg_pkg::OP_START && in_range
                     && step_rate_hz != '0;

  spg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (step_rate_hz),
    .done     (div_done),
    .quotient (div_q)
  );

  spg_ram #(
    .WIDTH (EW),
    .DEPTH (AXES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign ent      = spg_pkg::axis_entry_t'(ram_rdata);
  assign elapsed  = time_q - ent.last_us;
  assign hit      = p_vld && running[p_idx] && !ent.rate_zero
                    && elapsed >= {12'd0, ent.interval};
  assign stop_now = ent.steps == 24'd1;
  assign steps_n  = ent.steps != '0 ? ent.steps - 24'd1 : '0;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p_idx;
    ram_wdata = ent;
    case (state)
      ST_TICK: begin
        ram_we            = hit;
        ram_waddr         = p_idx;
        ram_wdata.last_us = time_q;
        ram_wdata.steps   = steps_n;
      end
      ST_WR: begin
        ram_we              = 1'b1;
        ram_waddr           = idx_q;
        ram_wdata.last_us   = time_q;
        ram_wdata.steps     = count_q;
        ram_wdata.interval  = rz_q ? '0 : div_q;
        ram_wdata.cdir      = dir_q;
        ram_wdata.rate_zero = rz_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  for (genvar i = 0; i < spg_pkg::OUT_W; i++) begin : g_out
    if (i < AXES) begin : g_used
      assign smask7[i] = smask[i];
      assign dir7[i]   = dir_pin[i];
      assign run7[i]   = running[i];
    end else begin : g_none
      assign smask7[i] = 1'b0;
      assign dir7[i]   = 1'b0;
      assign run7[i]   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      running   <= '0;
      dir_pin   <= '0;
      smask     <= '0;
      cnt       <= '0;
      p_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid    <= 1'b1;
        step_mask    <= smask7;
        dir_levels   <= dir7;
        running_mask <= run7;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            op_q    <= spg_pkg::op_t'(op);
            idx_q   <= axis_idx;
            time_q  <= time_us;
            count_q <= step_count;
            dir_q   <= direction;
            rz_q    <= step_rate_hz == '0;
            smask   <= '0;
            cnt     <= '0;
            p_vld   <= 1'b0;
            case (spg_pkg::op_t'(op))
              spg_pkg::OP_TICK: begin
                state <= ST_TICK;
              end
              spg_pkg::OP_START: begin
                if (!in_range) begin
                  state <= ST_FIN;
                end else if (step_rate_hz == '0) begin
                  state <= ST_WR;
                end else begin
                  state <= ST_DIV;
                end
              end
              spg_pkg::OP_STOP: begin
                if (in_range) begin
                  running[axis_idx] <= 1'b0;
                end
                state <= ST_FIN;
              end
              default: begin
                state <= ST_FIN;
              end
            endcase
          end
        end
        ST_TICK: begin
          // read of axis cnt overlaps update of axis p_idx
          p_vld <= cnt != CW'(AXES);
          p_idx <= cnt[AW-1:0];
          if (cnt != CW'(AXES)) begin
            cnt <= cnt + 1'b1;
          end else begin
            state <= ST_FIN;
          end
          if (hit) begin
            dir_pin[p_idx] <= ent.cdir;
            smask[p_idx]   <= 1'b1;
            if (stop_now) begin
              running[p_idx] <= 1'b0;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_WR;
          end
        end
        ST_WR: begin
          running[idx_q] <= 1'b1;
          state          <= ST_FIN;
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ram_quiet_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !ram_we)
    else $error("state memory written while idle");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside of a start");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    state == ST_WR |=> running[$past(idx_q)])
    else $error("started axis not running");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && spg_pkg::op_t'(op) == spg_pkg::OP_STOP && in_range)
      |=> !running[$past(axis_idx)])
    else $error("stopped axis still running");

  a_steps_only_tick: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && op_q != spg_pkg::OP_TICK) |-> smask == '0)
    else $error("step pulse on a non-tick beat");
`endif

endmodule

// ===== src/spg_ram.sv =====
module spg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/spg_div.sv =====
// Restoring divider: US_PER_SEC / divisor, one quotient bit per cycle.
module spg_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [spg_pkg::RATE_W-1:0] divisor,
  output logic                       done,
  output logic [spg_pkg::RATE_W-1:0] quotient
);

  localparam int W = spg_pkg::RATE_W;
  localparam int CW = $clog2(spg_pkg::DIV_STEPS);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic [W:0]    sh;
  logic [W:0]    diff;
  logic          fits;

  assign sh   = {rem, quo[W-1]};
  assign fits = sh >= {1'b0, dvs};
  assign diff = sh - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= spg_pkg::US_PER_SEC;
        dvs  <= divisor;
      end else if (busy) begin
        // remainder stays below the divisor, so the low W bits hold it
        rem <= fits ? diff[W-1:0] : sh[W-1:0];
        quo <= {quo[W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(spg_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== bench/multi_axis_step_pulse_generator_tb.sv =====
module multi_axis_step_pulse_generator_tb;

  localparam int AXES = spg_pkg::AXES_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 950;

  typedef struct {
    spg_pkg::op_t op;
    logic [2:0]   axis;
    logic [31:0]  time_us;
    logic [23:0]  count;
    logic [19:0]  rate;
    logic         dir;
    bit           drain;
  } beat_t;

  typedef struct {
    logic [6:0] steps;
    logic [6:0] pins;
    logic [6:0] run;
  } pulse_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = spg_pkg::OP_TICK;
  logic [2:0]  axis = '0;
  logic [31:0] time_us = '0;
  logic [23:0] step_count = '0;
  logic [19:0] step_rate_hz = '0;
  logic        direction = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  step_mask;
  logic [6:0]  dir_levels;
  logic [6:0]  running_mask;

  multi_axis_step_pulse_generator #(.AXES(AXES)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .axis(axis), .time_us(time_us), .step_count(step_count),
    .step_rate_hz(step_rate_hz), .direction(direction),
    .out_valid(out_valid), .out_stall(out_stall),
    .step_mask(step_mask), .dir_levels(dir_levels), .running_mask(running_mask)
  );

  always #4 clk = ~clk;

  beat_t  beat_q[$];
  pulse_t pulse_expect_q[$];
  int     errors = 0;
  int     pulses_seen = 0;

  // per-axis state of the predictor
  logic        ax_run[AXES];
  logic [23:0] ax_left[AXES];
  logic [19:0] ax_interval[AXES];
  logic        ax_cdir[AXES];
  logic        ax_pin[AXES];
  logic [31:0] ax_last[AXES];
  logic        ax_rate_zero[AXES];

  initial begin
    for (int a = 0; a < AXES; a++) begin
      ax_run[a] = 0; ax_left[a] = '0; ax_interval[a] = '0; ax_cdir[a] = 0;
      ax_pin[a] = 0; ax_last[a] = '0; ax_rate_zero[a] = 0;
    end
  end

  function automatic pulse_t step_predict(beat_t b);
    pulse_t      r;
    logic [31:0] elapsed;
    r.steps = '0; r.pins = '0; r.run = '0;
    case (b.op)
      spg_pkg::OP_TICK: begin
        for (int a = 0; a < AXES; a++) begin
          if (ax_run[a] && !ax_rate_zero[a]) begin
            elapsed = b.time_us - ax_last[a];
            if (elapsed >= 32'(ax_interval[a])) begin
              ax_last[a] = b.time_us;
              ax_pin[a] = ax_cdir[a];
              if (a < 7) r.steps[a] = 1'b1;
              if (ax_left[a] != 0) begin
                ax_left[a] = ax_left[a] - 1;
                if (ax_left[a] == 0) ax_run[a] = 0;
              end
            end
          end
        end
      end
      spg_pkg::OP_START: begin
        if (b.axis < AXES) begin
          ax_left[b.axis] = b.count;
          ax_cdir[b.axis] = b.dir;
          ax_last[b.axis] = b.time_us;
          ax_run[b.axis] = 1;
          ax_rate_zero[b.axis] = (b.rate == 0);
          ax_interval[b.axis] = (b.rate == 0) ? '0 :
                                20'(32'(spg_pkg::US_PER_SEC) / 32'(b.rate));
        end
      end
      spg_pkg::OP_STOP: begin
        if (b.axis < AXES) begin
          ax_run[b.axis] = 0;
          ax_left[b.axis] = '0;
        end
      end
      default: ;
    endcase
    for (int a = 0; a < AXES && a < 7; a++) begin
      r.pins[a] = ax_pin[a];
      r.run[a] = ax_run[a];
    end
    return r;
  endfunction

  task automatic add_beat(spg_pkg::op_t o, int ax, logic [31:0] t, logic [23:0] cnt,
                          logic [19:0] rt, logic d, bit drain = 0);
    beat_t b;
    b.op = o; b.axis = 3'(ax); b.time_us = t; b.count = cnt; b.rate = rt; b.dir = d;
    b.drain = drain;
    beat_q.push_back(b);
  endtask

  // sender: bursts of beats with random gaps
  beat_t cur;
  int    burst_left = 0;
  int    gap_left = 0;

  always @(posedge clk) begin : drive
    bit fire;
    bit show;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) pulse_expect_q.push_back(step_predict(cur));
      if (!in_valid || fire) begin
        show = 0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (beat_q.size() > 0 &&
                     !(beat_q[0].drain && pulse_expect_q.size() != 0)) begin
          cur = beat_q.pop_front();
          show = 1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end
        in_valid <= show;
        if (show) begin
          op <= cur.op;
          axis <= cur.axis;
          time_us <= cur.time_us;
          step_count <= cur.count;
          step_rate_hz <= cur.rate;
          direction <= cur.dir;
        end
      end
    end
  end

  // receiver: stall pattern changes mode now and then; one long hold-off
  int cyc = 0;
  int stall_mode = 0;
  int hold_left = 0;
  bit hold_done = 0;

  always @(posedge clk) begin : stall_gen
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      cyc++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && pulses_seen >= 300) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        if (cyc % 97 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (cyc % 7 < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check
    pulse_t want;
    if (!rst && out_valid && !out_stall) begin
      pulses_seen++;
      if (pulse_expect_q.size() == 0) begin
        $error("result beat with no expectation pending");
        errors++;
      end else begin
        want = pulse_expect_q.pop_front();
        if (step_mask !== want.steps) begin
          $error("step_mask expected %h actual %h", want.steps, step_mask);
          errors++;
        end
        if (dir_levels !== want.pins) begin
          $error("dir_levels expected %h actual %h", want.pins, dir_levels);
          errors++;
        end
        if (running_mask !== want.run) begin
          $error("running_mask expected %h actual %h", want.run, running_mask);
          errors++;
        end
      end
    end
  end

  int quiet = 0;

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : run
    logic [31:0] now;
    logic [19:0] rt;
    logic [23:0] cnt;
    int          n;
    int          ax;

    // directed beats
    add_beat(spg_pkg::OP_TICK, 0, 32'd0, '0, '0, 0);
    add_beat(spg_pkg::OP_NONE, 3, 32'd5, 24'hFFFFFF, 20'hFFFFF, 1);
    add_beat(spg_pkg::OP_START, 0, 32'd100, 24'd1, 20'd1000000, 1);
    add_beat(spg_pkg::OP_TICK, 0, 32'd100, '0, '0, 0);
    add_beat(spg_pkg::OP_TICK, 0, 32'd101, '0, '0, 0);        // single-step axis finishes
    add_beat(spg_pkg::OP_START, 6, 32'd200, 24'd5, 20'd0, 1);  // zero rate: runs, never steps
    add_beat(spg_pkg::OP_TICK, 0, 32'd5000, '0, '0, 0);
    add_beat(spg_pkg::OP_START, 7, 32'd300, 24'd3, 20'd1000, 1);  // out of range
    add_beat(spg_pkg::OP_STOP, 7, 32'd300, '0, '0, 0);
    add_beat(spg_pkg::OP_START, 1, 32'd400, 24'd0, 20'hFFFFF, 1); // interval 0, continuous
    add_beat(spg_pkg::OP_TICK, 0, 32'd400, '0, '0, 0);
    add_beat(spg_pkg::OP_TICK, 0, 32'd400, '0, '0, 0);
    add_beat(spg_pkg::OP_START, 1, 32'd401, 24'd2, 20'd1048575, 0); // reload while running
    add_beat(spg_pkg::OP_TICK, 0, 32'd401, '0, '0, 0);
    add_beat(spg_pkg::OP_TICK, 0, 32'd402, '0, '0, 0);
    add_beat(spg_pkg::OP_START, 2, 32'hFFFFFFFF, 24'hFFFFFF, 20'd1, 1);
    add_beat(spg_pkg::OP_TICK, 0, 32'd999998, '0, '0, 0);
    add_beat(spg_pkg::OP_TICK, 0, 32'd999999, '0, '0, 0);      // elapsed across the wrap
    add_beat(spg_pkg::OP_START, 5, 32'd0, 24'd3, 20'd500, 1);
    add_beat(spg_pkg::OP_START, 3, 32'd10, 24'd1, 20'd999999, 1);
    add_beat(spg_pkg::OP_TICK, 0, 32'd2000, '0, '0, 0);
    add_beat(spg_pkg::OP_STOP, 6, 32'd2001, '0, '0, 0);
    add_beat(spg_pkg::OP_STOP, 2, 32'd2002, '0, '0, 0);
    add_beat(spg_pkg::OP_STOP, 5, 32'd2003, '0, '0, 1, 1);

    // random part: mostly start-then-tick sequences, some noise
    now = 32'd3000;
    while (beat_q.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          add_beat(spg_pkg::op_t'(2'($urandom_range(0, 3))), $urandom_range(0, 7),
                   $urandom(), 24'($urandom()), 20'($urandom()), 1'($urandom()),
                   $urandom_range(0, 15) == 0);
        end
      end else begin
        if ($urandom_range(0, 5) == 0) now = $urandom();
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          ax = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 6);
          case ($urandom_range(0, 9))
            0: rt = '0;
            1: rt = 20'($urandom_range(1000001, 1048575));
            2: rt = 20'($urandom_range(1, 999));
            default: rt = 20'($urandom_range(1000, 1000000));
          endcase
          case ($urandom_range(0, 7))
            0: cnt = '0;
            1: cnt = 24'($urandom());
            default: cnt = 24'($urandom_range(1, 8));
          endcase
          add_beat(spg_pkg::OP_START, ax, now, cnt, rt, 1'($urandom()),
                   i == 0 && $urandom_range(0, 7) == 0);
        end
        n = $urandom_range(4, 20);
        repeat (n) begin
          case ($urandom_range(0, 9))
            0: now = now;
            1: now = now + $urandom_range(0, 2000000);
            2: now = now + $urandom();
            default: now = now + $urandom_range(1, 1500);
          endcase
          if ($urandom_range(0, 9) == 0)
            add_beat(spg_pkg::OP_STOP, $urandom_range(0, 7), now, 24'($urandom()),
                     20'($urandom()), 1'($urandom()));
          else
            add_beat(spg_pkg::OP_TICK, $urandom_range(0, 7), now, 24'($urandom()),
                     20'($urandom()), 1'($urandom()));
        end
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (beat_q.size() != 0 || in_valid || pulse_expect_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
src/spg_pkg.sv
src/spg_ram.sv
src/spg_div.sv
src/multi_axis_step_pulse_generator.sv
bench/multi_axis_step_pulse_generator_tb.sv
